[rtl/cau_pkg.sv]
// cau_pkg: shared types, constants and helper functions of the complex arithmetic unit
// no dependencies; every other file but cau_ifs imports this package

package cau_pkg;

    localparam int DATA_W           = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 30;
    localparam int DIV_STEPS        = 33;
    localparam int SQRT_STEPS       = 32;
    localparam int ITER_STAGES      = 33;
    localparam int QUEUE_DEPTH      = 4;
    localparam int CX_W             = 36;
    localparam int CZ_W             = 34;
    localparam int HALF_PI_Q30      = 1686629713;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // operation codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_CONJ  = 3'd4;
    localparam logic [2:0] OP_MAG   = 3'd5;
    localparam logic [2:0] OP_PHASE = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // classified item as it travels from the front to the back
    typedef struct packed {
        logic [2:0]  op;
        logic        b_zero;
        logic        a_zero;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
    } item_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    // saturate a 33-bit two's complement value to 32 bits
    function automatic sat_t sat_s33(input logic [32:0] v);
        sat_t r;
        r.sat = v[32] ^ v[31];
        r.val = r.sat ? (v[32] ? Q_MIN : Q_MAX) : v[31:0];
        return r;
    endfunction

    // sign and magnitude to a saturated 32-bit word
    function automatic sat_t sat_mag(input logic neg, input logic [64:0] mag);
        sat_t r;
        if (!neg)
        begin
            r.sat = |mag[64:31];
            r.val = r.sat ? Q_MAX : mag[31:0];
        end
        else
        begin
            r.sat = (|mag[64:32]) || (mag[31] && (|mag[30:0]));
            r.val = r.sat ? Q_MIN : (32'd0 - mag[31:0]);
        end
        return r;
    endfunction

    // atan(2^-i) in Q2.30, truncated
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000007;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/cau_ifs.sv]
// cau_in_if, cau_out_if: valid/ready channels of the complex arithmetic unit
// depends on nothing; widths follow the fixed Q16.16 word format

interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;

    modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic [1:0]         status;

    modport source (output valid, res_real, res_imag, status, input ready);
    modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

[rtl/cau_front.sv]
// cau_front: accepts operand transfers and classifies them into queue items
// depends on cau_pkg and cau_in_if

module cau_front
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    cau_in_if.sink   operands,
    output logic     push_valid,
    output item_t    push_item,
    input  logic     push_ready
);

    logic  f_vld_reg;
    item_t f_item_reg;
    item_t f_item_next;

    assign operands.ready = !f_vld_reg || push_ready;
    assign push_valid     = f_vld_reg;
    assign push_item      = f_item_reg;

    always_comb
    begin
        f_item_next.op     = operands.operation;
        f_item_next.b_zero = (operands.b_real == 32'sd0) && (operands.b_imag == 32'sd0);
        f_item_next.a_zero = (operands.a_real == 32'sd0) && (operands.a_imag == 32'sd0);
        f_item_next.ar     = operands.a_real;
        f_item_next.ai     = operands.a_imag;
        f_item_next.br     = operands.b_real;
        f_item_next.bi     = operands.b_imag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (operands.ready)
        begin
            f_vld_reg <= operands.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (operands.valid && operands.ready)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

[rtl/cau_queue.sv]
// cau_queue: short first-in first-out queue between front and back
// depends on cau_pkg

module cau_queue
    import cau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  push_ready,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop_ready
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg;
    logic [QA_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]  cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != QC_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != QC_W'(0));
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QA_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QA_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + QC_W'(1);
            end
            else if (!do_push && do_pop)
            begin
                cnt_reg <= cnt_reg - QC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/cau_back.sv]
// cau_back: execution pipeline (products, sums, divider, square root, cordic)
// depends on cau_pkg and cau_out_if

module cau_back
    import cau_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  item_t     item,
    output logic      item_ready,
    cau_out_if.source result
);

    localparam int STEPS     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int PRE_SHIFT = DIV_STEPS - FRAC_BITS;
    localparam int RND_SHIFT = 30 - FRAC_BITS;
    localparam int RW        = CZ_W + 1;
    localparam int PIPE_LEN  = 3 + ITER_STAGES + 1;
    localparam logic [RW-1:0] RND_HALF = RW'(1) << (29 - FRAC_BITS);

    typedef struct packed {
        logic [2:0]       op;
        logic             b_zero;
        logic             a_zero;
        logic [63:0]      p_rr;
        logic [63:0]      p_ii;
        logic [63:0]      p_ri;
        logic [63:0]      p_ir;
        logic [63:0]      p_br2;
        logic [63:0]      p_bi2;
        logic [63:0]      p_ar2;
        logic [63:0]      p_ai2;
        logic [31:0]      e_re;
        logic [31:0]      e_im;
        logic             e_sat;
        logic [CX_W-1:0]  cx;
        logic [CX_W-1:0]  cy;
        logic [CZ_W-1:0]  cz;
    } p0_t;

    typedef struct packed {
        logic [2:0]       op;
        logic             b_zero;
        logic             a_zero;
        logic [64:0]      m_re;
        logic [64:0]      m_im;
        logic [64:0]      d_re;
        logic [64:0]      d_im;
        logic [63:0]      den;
        logic [63:0]      sq;
        logic [31:0]      e_re;
        logic [31:0]      e_im;
        logic             e_sat;
        logic [CX_W-1:0]  cx;
        logic [CX_W-1:0]  cy;
        logic [CZ_W-1:0]  cz;
    } p1_t;

    typedef struct packed {
        logic [2:0]       op;
        logic             b_zero;
        logic             a_zero;
        logic             m_neg_re;
        logic             m_neg_im;
        logic [64:0]      m_mag_re;
        logic [64:0]      m_mag_im;
        logic             d_neg_re;
        logic             d_neg_im;
        logic [63:0]      d_mag_re;
        logic [63:0]      d_mag_im;
        logic [63:0]      den;
        logic [63:0]      sq;
        logic [31:0]      e_re;
        logic [31:0]      e_im;
        logic             e_sat;
        logic [CX_W-1:0]  cx;
        logic [CX_W-1:0]  cy;
        logic [CZ_W-1:0]  cz;
    } p2_t;

    typedef struct packed {
        logic [2:0]       op;
        logic             b_zero;
        logic             a_zero;
        logic [31:0]      e_re;
        logic [31:0]      e_im;
        logic             e_sat;
        logic             d_neg_re;
        logic             d_neg_im;
        logic             ovf_re;
        logic             ovf_im;
        logic [63:0]      den;
        logic [63:0]      n_re;
        logic [63:0]      n_im;
        logic [63:0]      r_re;
        logic [63:0]      r_im;
        logic [32:0]      q_re;
        logic [32:0]      q_im;
        logic [63:0]      sx;
        logic [35:0]      srem;
        logic [31:0]      sroot;
        logic [CX_W-1:0]  cx;
        logic [CX_W-1:0]  cy;
        logic [CZ_W-1:0]  cz;
    } it_t;

    logic                en;
    logic [PIPE_LEN-1:0] pipe_vld_reg;
    logic                out_vld_reg;
    logic [31:0]         out_re_reg;
    logic [31:0]         out_im_reg;
    logic [1:0]          out_st_reg;
    logic [31:0]         out_re_next;
    logic [31:0]         out_im_next;
    logic [1:0]          out_st_next;

    p0_t p0_reg;
    p0_t p0_next;
    p1_t p1_reg;
    p1_t p1_next;
    p2_t p2_reg;
    p2_t p2_next;
    it_t it_reg [0:ITER_STAGES];
    it_t it0_next;

    // whole pipeline advances together; the output register is the last stage
    assign en         = !out_vld_reg || result.ready;
    assign item_ready = en;

    assign result.valid    = out_vld_reg;
    assign result.res_real = out_re_reg;
    assign result.res_imag = out_im_reg;
    assign result.status   = out_st_reg;

    // products, add/sub/conj and cordic quarter turn
    always_comb
    begin
        sat_t s_re;
        sat_t s_im;
        logic [CX_W-1:0] x;
        logic [CX_W-1:0] y;
        s_re = '0;
        s_im = '0;
        x    = CX_W'($signed(item.ar));
        y    = CX_W'($signed(item.ai));

        p0_next.op     = item.op;
        p0_next.b_zero = item.b_zero;
        p0_next.a_zero = item.a_zero;
        p0_next.p_rr   = $signed(item.ar) * $signed(item.br);
        p0_next.p_ii   = $signed(item.ai) * $signed(item.bi);
        p0_next.p_ri   = $signed(item.ar) * $signed(item.bi);
        p0_next.p_ir   = $signed(item.ai) * $signed(item.br);
        p0_next.p_br2  = $signed(item.br) * $signed(item.br);
        p0_next.p_bi2  = $signed(item.bi) * $signed(item.bi);
        p0_next.p_ar2  = $signed(item.ar) * $signed(item.ar);
        p0_next.p_ai2  = $signed(item.ai) * $signed(item.ai);

        case (item.op)
            OP_ADD:
            begin
                s_re = sat_s33(33'($signed(item.ar)) + 33'($signed(item.br)));
                s_im = sat_s33(33'($signed(item.ai)) + 33'($signed(item.bi)));
            end
            OP_SUB:
            begin
                s_re = sat_s33(33'($signed(item.ar)) - 33'($signed(item.br)));
                s_im = sat_s33(33'($signed(item.ai)) - 33'($signed(item.bi)));
            end
            OP_CONJ:
            begin
                s_re.val = item.ar;
                s_re.sat = 1'b0;
                s_im     = sat_s33(33'd0 - 33'($signed(item.ai)));
            end
            default:
            begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        p0_next.e_re  = s_re.val;
        p0_next.e_im  = s_im.val;
        p0_next.e_sat = s_re.sat || s_im.sat;

        // turn a left half plane operand into the right half plane
        if (item.ar[31])
        begin
            if (!item.ai[31])
            begin
                p0_next.cx = y;
                p0_next.cy = CX_W'(0) - x;
                p0_next.cz = CZ_W'(HALF_PI_Q30);
            end
            else
            begin
                p0_next.cx = CX_W'(0) - y;
                p0_next.cy = x;
                p0_next.cz = CZ_W'(0) - CZ_W'(HALF_PI_Q30);
            end
        end
        else
        begin
            p0_next.cx = x;
            p0_next.cy = y;
            p0_next.cz = '0;
        end
    end

    // sums of products
    always_comb
    begin
        p1_next.op     = p0_reg.op;
        p1_next.b_zero = p0_reg.b_zero;
        p1_next.a_zero = p0_reg.a_zero;
        p1_next.m_re   = 65'($signed(p0_reg.p_rr)) - 65'($signed(p0_reg.p_ii));
        p1_next.m_im   = 65'($signed(p0_reg.p_ri)) + 65'($signed(p0_reg.p_ir));
        p1_next.d_re   = 65'($signed(p0_reg.p_rr)) + 65'($signed(p0_reg.p_ii));
        p1_next.d_im   = 65'($signed(p0_reg.p_ir)) - 65'($signed(p0_reg.p_ri));
        p1_next.den    = p0_reg.p_br2 + p0_reg.p_bi2;
        p1_next.sq     = p0_reg.p_ar2 + p0_reg.p_ai2;
        p1_next.e_re   = p0_reg.e_re;
        p1_next.e_im   = p0_reg.e_im;
        p1_next.e_sat  = p0_reg.e_sat;
        p1_next.cx     = p0_reg.cx;
        p1_next.cy     = p0_reg.cy;
        p1_next.cz     = p0_reg.cz;
    end

    // sign and magnitude
    always_comb
    begin
        logic [64:0] dm_re;
        logic [64:0] dm_im;
        dm_re = p1_reg.d_re[64] ? (65'd0 - p1_reg.d_re) : p1_reg.d_re;
        dm_im = p1_reg.d_im[64] ? (65'd0 - p1_reg.d_im) : p1_reg.d_im;

        p2_next.op       = p1_reg.op;
        p2_next.b_zero   = p1_reg.b_zero;
        p2_next.a_zero   = p1_reg.a_zero;
        p2_next.m_neg_re = p1_reg.m_re[64];
        p2_next.m_neg_im = p1_reg.m_im[64];
        p2_next.m_mag_re = p1_reg.m_re[64] ? (65'd0 - p1_reg.m_re) : p1_reg.m_re;
        p2_next.m_mag_im = p1_reg.m_im[64] ? (65'd0 - p1_reg.m_im) : p1_reg.m_im;
        p2_next.d_neg_re = p1_reg.d_re[64];
        p2_next.d_neg_im = p1_reg.d_im[64];
        p2_next.d_mag_re = dm_re[63:0];
        p2_next.d_mag_im = dm_im[63:0];
        p2_next.den      = p1_reg.den;
        p2_next.sq       = p1_reg.sq;
        p2_next.e_re     = p1_reg.e_re;
        p2_next.e_im     = p1_reg.e_im;
        p2_next.e_sat    = p1_reg.e_sat;
        p2_next.cx       = p1_reg.cx;
        p2_next.cy       = p1_reg.cy;
        p2_next.cz       = p1_reg.cz;
    end

    // multiply result, divider overflow check and setup of the iterations
    always_comb
    begin
        sat_t mr;
        sat_t mi;
        logic [63+PRE_SHIFT:0] den_sh;
        mr     = sat_mag(p2_reg.m_neg_re, p2_reg.m_mag_re >> FRAC_BITS);
        mi     = sat_mag(p2_reg.m_neg_im, p2_reg.m_mag_im >> FRAC_BITS);
        den_sh = {p2_reg.den, PRE_SHIFT'(0)};

        it0_next.op     = p2_reg.op;
        it0_next.b_zero = p2_reg.b_zero;
        it0_next.a_zero = p2_reg.a_zero;
        if (p2_reg.op == OP_MUL)
        begin
            it0_next.e_re  = mr.val;
            it0_next.e_im  = mi.val;
            it0_next.e_sat = mr.sat || mi.sat;
        end
        else
        begin
            it0_next.e_re  = p2_reg.e_re;
            it0_next.e_im  = p2_reg.e_im;
            it0_next.e_sat = p2_reg.e_sat;
        end
        it0_next.d_neg_re = p2_reg.d_neg_re;
        it0_next.d_neg_im = p2_reg.d_neg_im;
        // quotient would need more than the 33 bits the divider makes
        it0_next.ovf_re   = {PRE_SHIFT'(0), p2_reg.d_mag_re} >= den_sh;
        it0_next.ovf_im   = {PRE_SHIFT'(0), p2_reg.d_mag_im} >= den_sh;
        it0_next.den      = p2_reg.den;
        it0_next.n_re     = p2_reg.d_mag_re;
        it0_next.n_im     = p2_reg.d_mag_im;
        it0_next.r_re     = p2_reg.d_mag_re >> PRE_SHIFT;
        it0_next.r_im     = p2_reg.d_mag_im >> PRE_SHIFT;
        it0_next.q_re     = '0;
        it0_next.q_im     = '0;
        it0_next.sx       = p2_reg.sq;
        it0_next.srem     = '0;
        it0_next.sroot    = '0;
        it0_next.cx       = p2_reg.cx;
        it0_next.cy       = p2_reg.cy;
        it0_next.cz       = p2_reg.cz;
    end

    // stage k: quotient bit; root bit if k < SQRT_STEPS; cordic if k < STEPS
    for (genvar k = 0; k < ITER_STAGES; k++)
    begin : g_iter
        localparam int DBIT = DIV_STEPS - 1 - k;
        localparam int XI   = (DBIT >= FRAC_BITS) ? (DBIT - FRAC_BITS) : 0;
        localparam int SJ   = (k < SQRT_STEPS) ? (SQRT_STEPS - 1 - k) : 0;
        localparam int CK   = (k < STEPS) ? k : 0;

        it_t stg_next;

        always_comb
        begin
            logic        xb_re;
            logic        xb_im;
            logic [64:0] rs_re;
            logic [64:0] rs_im;
            logic [64:0] dd;
            logic [35:0] rem2;
            logic [35:0] trial;
            logic [CX_W-1:0] dx;
            logic [CX_W-1:0] dy;
            logic [CZ_W-1:0] da;
            logic        ypos;

            stg_next = it_reg[k];
            xb_re    = (DBIT >= FRAC_BITS) ? it_reg[k].n_re[XI] : 1'b0;
            xb_im    = (DBIT >= FRAC_BITS) ? it_reg[k].n_im[XI] : 1'b0;
            dd       = {1'b0, it_reg[k].den};
            rs_re    = {it_reg[k].r_re, xb_re};
            rs_im    = {it_reg[k].r_im, xb_im};

            if (rs_re >= dd)
            begin
                stg_next.r_re = 64'(rs_re - dd);
                stg_next.q_re = {it_reg[k].q_re[31:0], 1'b1};
            end
            else
            begin
                stg_next.r_re = rs_re[63:0];
                stg_next.q_re = {it_reg[k].q_re[31:0], 1'b0};
            end
            if (rs_im >= dd)
            begin
                stg_next.r_im = 64'(rs_im - dd);
                stg_next.q_im = {it_reg[k].q_im[31:0], 1'b1};
            end
            else
            begin
                stg_next.r_im = rs_im[63:0];
                stg_next.q_im = {it_reg[k].q_im[31:0], 1'b0};
            end

            rem2  = {it_reg[k].srem[33:0], it_reg[k].sx[2*SJ+1 -: 2]};
            trial = {2'b00, it_reg[k].sroot, 2'b01};
            if (k < SQRT_STEPS)
            begin
                if (rem2 >= trial)
                begin
                    stg_next.srem  = rem2 - trial;
                    stg_next.sroot = {it_reg[k].sroot[30:0], 1'b1};
                end
                else
                begin
                    stg_next.srem  = rem2;
                    stg_next.sroot = {it_reg[k].sroot[30:0], 1'b0};
                end
            end

            dx   = CX_W'($signed(it_reg[k].cy) >>> CK);
            dy   = CX_W'($signed(it_reg[k].cx) >>> CK);
            da   = {2'b00, atan_q30(CK)};
            ypos = !it_reg[k].cy[CX_W-1] && (|it_reg[k].cy);
            if (k < STEPS)
            begin
                if (ypos)
                begin
                    stg_next.cx = it_reg[k].cx + dx;
                    stg_next.cy = it_reg[k].cy - dy;
                    stg_next.cz = it_reg[k].cz + da;
                end
                else
                begin
                    stg_next.cx = it_reg[k].cx - dx;
                    stg_next.cy = it_reg[k].cy + dy;
                    stg_next.cz = it_reg[k].cz - da;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_reg[k+1] <= stg_next;
            end
        end
    end

    // result selection and saturation
    always_comb
    begin
        sat_t dr;
        sat_t di;
        sat_t mg;
        logic [RW-1:0] rz;
        logic [RW-1:0] ph;
        dr = sat_mag(it_reg[ITER_STAGES].d_neg_re, 65'(it_reg[ITER_STAGES].q_re));
        di = sat_mag(it_reg[ITER_STAGES].d_neg_im, 65'(it_reg[ITER_STAGES].q_im));
        if (it_reg[ITER_STAGES].ovf_re)
        begin
            dr.sat = 1'b1;
            dr.val = it_reg[ITER_STAGES].d_neg_re ? Q_MIN : Q_MAX;
        end
        if (it_reg[ITER_STAGES].ovf_im)
        begin
            di.sat = 1'b1;
            di.val = it_reg[ITER_STAGES].d_neg_im ? Q_MIN : Q_MAX;
        end
        mg = sat_mag(1'b0, 65'(it_reg[ITER_STAGES].sroot));
        rz = RW'($signed(it_reg[ITER_STAGES].cz)) + RND_HALF;
        ph = RW'($signed(rz) >>> RND_SHIFT);

        out_re_next = '0;
        out_im_next = '0;
        out_st_next = ST_OK;
        case (it_reg[ITER_STAGES].op)
            OP_ADD, OP_SUB, OP_MUL, OP_CONJ:
            begin
                out_re_next = it_reg[ITER_STAGES].e_re;
                out_im_next = it_reg[ITER_STAGES].e_im;
                out_st_next = it_reg[ITER_STAGES].e_sat ? ST_SAT : ST_OK;
            end
            OP_DIV:
            begin
                if (it_reg[ITER_STAGES].b_zero)
                begin
                    out_st_next = ST_DIV0;
                end
                else
                begin
                    out_re_next = dr.val;
                    out_im_next = di.val;
                    out_st_next = (dr.sat || di.sat) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG:
            begin
                out_re_next = mg.val;
                out_st_next = mg.sat ? ST_SAT : ST_OK;
            end
            OP_PHASE:
            begin
                out_re_next = it_reg[ITER_STAGES].a_zero ? 32'd0 : ph[31:0];
            end
            default:
            begin
                out_re_next = '0;
                out_im_next = '0;
                out_st_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            pipe_vld_reg <= {pipe_vld_reg[PIPE_LEN-2:0], item_valid};
            out_vld_reg  <= pipe_vld_reg[PIPE_LEN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg     <= p0_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            it_reg[0]  <= it0_next;
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
            out_st_reg <= out_st_next;
        end
    end

    // divide by zero always comes with a zero result
    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_st_reg == ST_DIV0) |-> (out_re_reg == 32'd0) && (out_im_reg == 32'd0))
        else $error("divide by zero result not zero");

    // a saturated result has at least one part at a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_st_reg == ST_SAT) |->
            (out_re_reg == Q_MAX) || (out_re_reg == Q_MIN) ||
            (out_im_reg == Q_MAX) || (out_im_reg == Q_MIN))
        else $error("saturated status without a clamped part");

    // a stalled pipeline keeps its occupancy
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(pipe_vld_reg) && out_vld_reg)
        else $error("pipeline moved while stalled");

endmodule

[rtl/complex_arithmetic_unit.sv]
// complex_arithmetic_unit: top level of the Q16.16 complex arithmetic unit
// depends on cau_pkg, cau_ifs, cau_front, cau_queue and cau_back
//
//  channel    dir  handshake      payload
//  operands   in   valid/ready    operation, a_real, a_imag, b_real, b_imag
//  result     out  valid/ready    res_real, res_imag, status
//
//  one transfer per cycle in and out when neither side stalls
//  every item passes through the 33 quotient-bit stages of the divider, which set
//    the length of the back pipeline
//  reset is asynchronous and active low; it empties all valid bits at once
//  a result stall freezes the back pipeline; the queue and front register
//    keep taking items until four plus one are waiting

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    cau_in_if.sink     operands,
    cau_out_if.source  result
);

    // front to queue
    logic  push_valid;
    logic  push_ready;
    item_t push_item;

    // queue to back
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    // accept and classify (zero operands for divide and phase)
    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .operands   (operands),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // lets the front keep accepting while the back is stalled
    cau_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // products, sums, divider, square root and cordic in one lockstep pipeline
    cau_back #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item       (pop_item),
        .item_ready (pop_ready),
        .result     (result)
    );

endmodule

[dv/tb_complex_arithmetic_unit.sv]
// tb_complex_arithmetic_unit: self-checking regression of the Q16.16 complex arithmetic unit
// depends on cau_pkg, cau_ifs and the complex_arithmetic_unit rtl; needs no other file

module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // operation code with no operation behind it
    localparam logic [2:0] OP_NONE = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 900;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0]         st;
    } cx_result_t;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
        bit                 typed;  // expected result written in the row
        cx_result_t         res;
    } stim_row_t;

    typedef logic signed [97:0] wide_t;

    // atan(2^-i) in Q2.30, truncated
    localparam logic [31:0] ARCTAN_Q30 [30] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    logic clk;
    logic rst_n;

    cau_in_if  operands_if ();
    cau_out_if result_if ();

    complex_arithmetic_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_if),
        .result   (result_if)
    );

    cx_result_t pending_results [$];
    int  mismatch_count;
    int  result_count;
    int  quiet_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  op_seen [8];

    // clamp a wide signed value into a Q16.16 word, flagging saturation
    function automatic logic signed [31:0] clamp_word(input wide_t v, inout bit sat);
        if (v > wide_t'(32'sh7FFF_FFFF))
        begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < -wide_t'(64'sh8000_0000))
        begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // signed shift right by frac bits, truncating toward zero
    function automatic wide_t trunc_shift(input wide_t v);
        return (v < 0) ? -((-v) >>> 16) : (v >>> 16);
    endfunction

    // magnitude of num * 2^16 / den rounded down, with the sign of num carried over
    function automatic wide_t frac_quotient(input wide_t num, input wide_t den);
        wide_t m;
        m = (num < 0) ? -num : num;
        m = (m <<< 16) / den;
        return (num < 0) ? -m : m;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] acc;
        logic [63:0] bitv;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= acc + bitv)
            begin
                x   = x - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end
            else
                acc = acc >> 1;
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    // vectoring cordic, angle in Q2.30 then rounded to Q16.16
    function automatic longint phase_angle(input longint x, input longint y);
        longint z;
        longint nx;
        longint ny;
        longint dx;
        longint dy;
        int steps;
        steps = (CORDIC_STEPS_DEF > 30) ? 30 : CORDIC_STEPS_DEF;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                nx = y;
                ny = -x;
                z  = HALF_PI_Q30;
            end
            else
            begin
                nx = -y;
                ny = x;
                z  = -longint'(HALF_PI_Q30);
            end
            x = nx;
            y = ny;
        end
        for (int i = 0; i < steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ARCTAN_Q30[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ARCTAN_Q30[i]);
            end
        end
        return (z + (longint'(1) << 13)) >>> 14;
    endfunction

    function automatic cx_result_t complex_result(input logic [2:0] op,
        input logic signed [31:0] ar, input logic signed [31:0] ai,
        input logic signed [31:0] br, input logic signed [31:0] bi);
        cx_result_t r;
        bit sat;
        wide_t war;
        wide_t wai;
        wide_t wbr;
        wide_t wbi;
        wide_t den;
        logic [63:0] sq;
        war = ar;
        wai = ai;
        wbr = br;
        wbi = bi;
        sat = 1'b0;
        r   = '0;
        r.st = ST_OK;
        case (op)
            OP_ADD:
            begin
                r.re = clamp_word(war + wbr, sat);
                r.im = clamp_word(wai + wbi, sat);
            end
            OP_SUB:
            begin
                r.re = clamp_word(war - wbr, sat);
                r.im = clamp_word(wai - wbi, sat);
            end
            OP_MUL:
            begin
                r.re = clamp_word(trunc_shift(war * wbr - wai * wbi), sat);
                r.im = clamp_word(trunc_shift(war * wbi + wai * wbr), sat);
            end
            OP_DIV:
            begin
                if (br == 0 && bi == 0)
                    r.st = ST_DIV0;
                else
                begin
                    den  = wbr * wbr + wbi * wbi;
                    r.re = clamp_word(frac_quotient(war * wbr + wai * wbi, den), sat);
                    r.im = clamp_word(frac_quotient(wai * wbr - war * wbi, den), sat);
                end
            end
            OP_CONJ:
            begin
                r.re = ar;
                r.im = clamp_word(-wai, sat);
            end
            OP_MAG:
            begin
                sq   = 64'(war * war + wai * wai);
                r.re = clamp_word(wide_t'(root_floor(sq)), sat);
            end
            OP_PHASE:
                r.re = clamp_word(wide_t'(phase_angle(longint'(ar), longint'(ai))), sat);
            default:
                ;
        endcase
        if (sat && r.st == ST_OK)
            r.st = ST_SAT;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // one operand transfer; the expectation is queued once it is taken
    task automatic drive_operands(input stim_row_t row);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            operands_if.valid <= 1'b0;
            @(posedge clk);
        end
        operands_if.valid     <= 1'b1;
        operands_if.operation <= row.op;
        operands_if.a_real    <= row.ar;
        operands_if.a_imag    <= row.ai;
        operands_if.b_real    <= row.br;
        operands_if.b_imag    <= row.bi;
        do
            @(posedge clk);
        while (!operands_if.ready);
        op_seen[row.op]++;
        if (row.typed)
            pending_results.push_back(row.res);
        else
            pending_results.push_back(complex_result(row.op, row.ar, row.ai, row.br, row.bi));
    endtask

    // operand word: full range, small Q16.16 values, exact zero or an extreme
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(32'h0020_0000, 0)) - 32'sh0010_0000;
            7:          return 32'sh0;
            8:          return Q_MAX;
            default:    return Q_MIN;
        endcase
    endfunction

    stim_row_t directed_rows [$];

    initial
    begin
        stim_row_t row;
        operands_if.valid     = 1'b0;
        operands_if.operation = OP_ADD;
        operands_if.a_real    = '0;
        operands_if.a_imag    = '0;
        operands_if.b_real    = '0;
        operands_if.b_imag    = '0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;

        // extremes and special cases with the answer written in
        directed_rows = '{
            '{OP_ADD,   Q_MAX, 32'sh0, Q_MAX, 32'sh0, 1'b1, '{Q_MAX, 32'sh0, ST_SAT}},
            '{OP_SUB,   Q_MIN, 32'sh0, 32'sh1, 32'sh0, 1'b1, '{Q_MIN, 32'sh0, ST_SAT}},
            '{OP_DIV,   32'sh1234, -32'sh5, 32'sh0, 32'sh0, 1'b1, '{32'sh0, 32'sh0, ST_DIV0}},
            '{OP_CONJ,  32'sh5, Q_MIN, 32'sh0, 32'sh0, 1'b1, '{32'sh5, Q_MAX, ST_SAT}},
            '{OP_MAG,   Q_MIN, Q_MIN, 32'sh0, 32'sh0, 1'b1, '{Q_MAX, 32'sh0, ST_SAT}},
            '{OP_PHASE, 32'sh0, 32'sh0, 32'sh7, 32'sh7, 1'b1, '{32'sh0, 32'sh0, ST_OK}},
            '{OP_NONE,  Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1, '{32'sh0, 32'sh0, ST_OK}},
            '{OP_MUL,   32'sh10000, 32'sh0, 32'sh10000, 32'sh0, 1'b1,
              '{32'sh10000, 32'sh0, ST_OK}},
            // the rest against the predictor
            '{OP_ADD,   32'sh18000, -32'sh4000, -32'sh8000, 32'sh1, 1'b0, '0},
            '{OP_SUB,   Q_MAX, Q_MIN, Q_MIN, Q_MAX, 1'b0, '0},
            '{OP_MUL,   Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, '0},
            '{OP_MUL,   -32'sh18000, 32'sh20000, 32'sh8000, -32'sh3, 1'b0, '0},
            '{OP_DIV,   32'sh30000, 32'sh10000, 32'sh0, 32'sh20000, 1'b0, '0},
            '{OP_DIV,   Q_MAX, Q_MAX, 32'sh1, 32'sh0, 1'b0, '0},
            '{OP_DIV,   Q_MIN, 32'sh1, Q_MIN, Q_MIN, 1'b0, '0},
            '{OP_CONJ,  -32'sh7, Q_MAX, 32'sh0, 32'sh0, 1'b0, '0},
            '{OP_MAG,   32'sh30000, -32'sh40000, 32'sh0, 32'sh0, 1'b0, '0},
            '{OP_MAG,   Q_MAX, 32'sh0, 32'sh0, 32'sh0, 1'b0, '0},
            '{OP_PHASE, -32'sh10000, 32'sh0, 32'sh0, 32'sh0, 1'b0, '0},
            '{OP_PHASE, -32'sh10000, -32'sh1, 32'sh0, 32'sh0, 1'b0, '0},
            '{OP_PHASE, 32'sh0, -32'sh10000, 32'sh0, 32'sh0, 1'b0, '0},
            '{OP_PHASE, Q_MIN, Q_MAX, 32'sh0, 32'sh0, 1'b0, '0},
            '{OP_PHASE, 32'sh10000, 32'sh10000, 32'sh0, 32'sh0, 1'b0, '0}
        };

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (directed_rows[i])
            drive_operands(directed_rows[i]);

        // random part in four idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 86 : (phase == 3) ? 38 : 0;
            recv_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 38 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                row.op    = 3'($urandom_range(7, 0));
                row.ar    = pick_word();
                row.ai    = pick_word();
                row.br    = pick_word();
                row.bi    = pick_word();
                row.typed = 1'b0;
                row.res   = '0;
                // now and then a zero divisor
                if (row.op == OP_DIV && $urandom_range(9, 0) == 0)
                begin
                    row.br = '0;
                    row.bi = '0;
                end
                drive_operands(row);
            end
        end
        operands_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d results over ops add %0d sub %0d mul %0d div %0d conj %0d",
            result_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
        $display("  mag %0d phase %0d unused %0d, four sender/receiver idling phases",
            op_seen[5], op_seen[6], op_seen[7]);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("complex_arithmetic_unit regression: pass");
        else
            $display("complex_arithmetic_unit regression: fail");
        $finish;
    end

    // result side: compare every transfer, then decide the next ready
    always @(posedge clk)
    begin
        cx_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expectation waiting");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_if.res_real !== want.re)
                begin
                    $error("res_real expected %h actual %h", want.re, result_if.res_real);
                    mismatch_count++;
                end
                if (result_if.res_imag !== want.im)
                begin
                    $error("res_imag expected %h actual %h", want.im, result_if.res_imag);
                    mismatch_count++;
                end
                if (result_if.status !== want.st)
                begin
                    $error("status expected %0d actual %0d", want.st, result_if.status);
                    mismatch_count++;
                end
            end
        end
        result_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (operands_if.valid && operands_if.ready)
            || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("complex_arithmetic_unit regression: fail");
            $finish;
        end
    end

endmodule
